// ===== hw/rtl/wsd_pkg.sv =====
// wsd_pkg: shared types and constants for the websocket frame deframer
// no dependencies; used by the stream interface users, the top level and the checker

package wsd_pkg;

    // second header byte length codes
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // last byte index of each header field, counted from zero
    localparam logic [2:0] LEN16_LAST_IDX = 3'd1;
    localparam logic [2:0] LEN64_LAST_IDX = 3'd7;
    localparam logic [2:0] MASK_LAST_IDX  = 3'd3;

    // one received beat
    typedef struct packed {
        logic [7:0] in_byte;
    } in_item_t;

    // one result beat
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_payload;
        logic       fin_flag;
        logic [3:0] frame_opcode;
        logic       frame_end;
        logic       unmasked_error;
    } out_item_t;

endpackage

// ===== hw/rtl/wsd_stream_if.sv =====
// wsd_stream_if: valid/ready stream channel carrying one payload beat
// no dependencies; the payload type is set where the channel is instantiated

interface wsd_stream_if #(
    parameter type data_t = logic [7:0]
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/websocket_frame_deframer_top.sv =====
// a result beat is registered and is valid in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle while the input is ready; the 64-bit remaining-length decrement
//   and compare and the header/payload decode are all combinational before the result register
// the input stays ready while the result register is empty or being drained
// reset (rst_n low, asynchronous) returns to waiting for the first header byte
//   and empties the result register
module websocket_frame_deframer_top (
    input logic          clk,
    input logic          rst_n,
    wsd_stream_if.sink   in_stream,
    wsd_stream_if.source out_stream
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_LEN16   = 3'd2,
        PH_LEN64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  mask_pos_reg, mask_pos_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic        accept;
    logic [7:0]  b;
    logic        emit;
    out_item_t   res;
    logic [63:0] len_shift;
    logic [2:0]  len_last;
    logic        pay_last;
    logic [7:0]  key_byte;

    // input is free when the result register is empty or drains this cycle
    assign in_stream.ready = !out_valid_reg || out_stream.ready;
    assign accept          = in_stream.valid && in_stream.ready;
    assign b               = in_stream.data.in_byte;

    assign len_shift = {remain_reg[55:0], b};
    assign len_last  = (phase_reg == PH_LEN16) ? LEN16_LAST_IDX : LEN64_LAST_IDX;
    assign pay_last  = (remain_reg <= 64'd1);
    assign key_byte  = key_reg[5'd24 - {mask_pos_reg, 3'b000} +: 8];

    // header decode and payload unmasking
    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        remain_next   = remain_reg;
        key_next      = key_reg;
        mask_pos_next = mask_pos_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        emit          = 1'b0;
        res.payload_byte   = 8'd0;
        res.has_payload    = 1'b0;
        res.fin_flag       = fin_reg;
        res.frame_opcode   = opcode_reg;
        res.frame_end      = 1'b0;
        res.unmasked_error = 1'b0;

        case (phase_reg)
            PH_SECOND:
            begin
                masked_next  = b[7];
                hdr_cnt_next = 3'd0;
                if (b[6:0] == LEN_CODE_16)
                begin
                    phase_next  = PH_LEN16;
                    remain_next = 64'd0;
                end
                else if (b[6:0] == LEN_CODE_64)
                begin
                    phase_next  = PH_LEN64;
                    remain_next = 64'd0;
                end
                else
                begin
                    remain_next = {57'd0, b[6:0]};
                    if (b[7])
                    begin
                        phase_next = PH_MASK;
                        key_next   = 32'd0;
                    end
                    else if (b[6:0] == 7'd0)
                    begin
                        // empty unmasked frame ends right here
                        phase_next         = PH_FIRST;
                        emit               = 1'b1;
                        res.frame_end      = 1'b1;
                        res.unmasked_error = 1'b1;
                    end
                    else
                    begin
                        phase_next    = PH_PAYLOAD;
                        mask_pos_next = 2'd0;
                    end
                end
            end
            PH_LEN16, PH_LEN64:
            begin
                remain_next = len_shift;
                if (hdr_cnt_reg >= len_last)
                begin
                    hdr_cnt_next = 3'd0;
                    if (masked_reg)
                    begin
                        phase_next = PH_MASK;
                        key_next   = 32'd0;
                    end
                    else if (len_shift == 64'd0)
                    begin
                        phase_next         = PH_FIRST;
                        emit               = 1'b1;
                        res.frame_end      = 1'b1;
                        res.unmasked_error = 1'b1;
                    end
                    else
                    begin
                        phase_next    = PH_PAYLOAD;
                        mask_pos_next = 2'd0;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                end
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], b};
                if (hdr_cnt_reg >= MASK_LAST_IDX)
                begin
                    hdr_cnt_next = 3'd0;
                    if (remain_reg == 64'd0)
                    begin
                        // empty masked frame
                        phase_next         = PH_FIRST;
                        emit               = 1'b1;
                        res.frame_end      = 1'b1;
                        res.unmasked_error = !masked_reg;
                    end
                    else
                    begin
                        phase_next    = PH_PAYLOAD;
                        mask_pos_next = 2'd0;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                end
            end
            PH_PAYLOAD:
            begin
                remain_next   = pay_last ? 64'd0 : remain_reg - 64'd1;
                mask_pos_next = mask_pos_reg + 2'd1;
                if (pay_last)
                begin
                    phase_next = PH_FIRST;
                end
                if (masked_reg)
                begin
                    emit             = 1'b1;
                    res.payload_byte = b ^ key_byte;
                    res.has_payload  = 1'b1;
                    res.frame_end    = pay_last;
                end
                else if (pay_last)
                begin
                    // unmasked payload is dropped, one error beat closes it
                    emit               = 1'b1;
                    res.frame_end      = 1'b1;
                    res.unmasked_error = 1'b1;
                end
            end
            default:
            begin
                fin_next    = b[7];
                opcode_next = b[3:0];
                phase_next  = PH_SECOND;
            end
        endcase
    end

    // result register load and drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            hdr_cnt_reg   <= 3'd0;
            remain_reg    <= 64'd0;
            key_reg       <= 32'd0;
            mask_pos_reg  <= 2'd0;
            fin_reg       <= 1'b0;
            opcode_reg    <= 4'd0;
            masked_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                hdr_cnt_reg  <= hdr_cnt_next;
                remain_reg   <= remain_next;
                key_reg      <= key_next;
                mask_pos_reg <= mask_pos_next;
                fin_reg      <= fin_next;
                opcode_reg   <= opcode_next;
                masked_reg   <= masked_next;
            end
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_stream.valid = out_valid_reg;
    assign out_stream.data  = out_data_reg;

endmodule

// ===== hw/rtl/wsd_checker.sv =====
// wsd_checker: port-level checks on the websocket frame deframer
// depends on wsd_pkg; bound to websocket_frame_deframer_top below

module wsd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input wsd_pkg::out_item_t out_data
);
    import wsd_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // a full, stalled result register blocks the input
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input ready while result register is full and stalled");

    // data beats never carry the unmasked error
    a_pay_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.has_payload |-> !out_data.unmasked_error)
        else $error("payload beat flagged as unmasked");

    // beats without payload close a frame and carry a zero byte
    a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.has_payload |-> out_data.frame_end &&
            out_data.payload_byte == 8'd0)
        else $error("payload-free beat does not end the frame");

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_data  (out_stream.data)
);
